### rtl/nearest_point_search_2d_assert.svh
// Assertion macros for the nearest point search RTL.
// Standalone header; nearest_point_search_2d includes it to check its own logic.
`ifndef NEAREST_POINT_SEARCH_2D_ASSERT_SVH
`define NEAREST_POINT_SEARCH_2D_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nps assertion failed");
`define NPS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("nps forbidden condition");
`else
`define NPS_ASSERT(lbl, clk, rst, prop)
`define NPS_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

### rtl/nps_pkg.sv
// Types and constants for the nearest point search block.
// No dependencies; used by nps_dist and nearest_point_search_2d.
package nps_pkg;

   localparam int MAX_POINTS_DEF = 1024;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam int ENTRY_W = 2 * COORD_W;
   localparam int IDX_W   = 11;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [IDX_W-1:0]  index;
   } nps_tag_type;

endpackage

### rtl/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nps_dist.sv
// Two-stage squared distance pipeline: differences, then squares.
// Depends on nps_pkg.
module nps_dist (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [nps_pkg::COORD_W-1:0]    query_x,
   input  logic signed [nps_pkg::COORD_W-1:0]    query_y,
   input  logic [nps_pkg::ENTRY_W-1:0]           ref_data,
   input  nps_pkg::nps_tag_type                  tag_in,
   output logic [nps_pkg::DIST_W-1:0]            sq_dist,
   output nps_pkg::nps_tag_type                  tag_out
);

   logic signed [nps_pkg::DIFF_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic signed [2*nps_pkg::DIFF_W-1:0] prod_x, prod_y;
   logic [nps_pkg::SQ_W-1:0]            sqx_ff, sqy_ff;
   nps_pkg::nps_tag_type                tag1_ff, tag2_ff;

   always_comb begin
      dx_in = nps_pkg::DIFF_W'(query_x)
            - nps_pkg::DIFF_W'($signed(ref_data[nps_pkg::COORD_W-1:0]));
      dy_in = nps_pkg::DIFF_W'(query_y)
            - nps_pkg::DIFF_W'($signed(ref_data[nps_pkg::ENTRY_W-1:nps_pkg::COORD_W]));
      prod_x = dx_ff * dx_ff;
      prod_y = dy_ff * dy_ff;
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= prod_x[nps_pkg::SQ_W-1:0];
      sqy_ff <= prod_y[nps_pkg::SQ_W-1:0];
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   assign sq_dist = nps_pkg::DIST_W'(sqx_ff) + nps_pkg::DIST_W'(sqy_ff);
   assign tag_out = tag2_ff;

endmodule

### rtl/nearest_point_search_2d.sv
// Top level of the nearest point search: command port, scan sequencer, minimum tracking.
// Depends on nps_pkg, nps_ram, nps_dist and nearest_point_search_2d_assert.svh.
//
// Usage:
//   Items enter on req_* with start; an item transfers at a clock edge where start
//   is high and busy is low. A load (req_action 0) writes req_point_x/req_point_y
//   into reference slot req_slot in that cycle and gives no response; slots at or
//   above MAX_POINTS are dropped. A query (req_action 1) scans reference points
//   0 .. min(ref_count, MAX_POINTS)-1 and gives one response on rsp_* marked by
//   rsp_strobe for a single cycle; the receiver cannot hold it off.
//   ref_count is written over the csr_ channel (csr_valid with csr_ready).
// Timing:
//   A load never raises busy. A query over N points issues one RAM read per cycle
//   while scanning; each point then passes the read, difference and square stages,
//   and the response is registered after the last point; an empty query responds
//   in the next cycle. busy falls with the response, so a new item can transfer at
//   the edge ending it. The single RAM read port sets one point per cycle.
// Reset:
//   Synchronous; clears ref_count and the sequencer. Reference RAM is not cleared;
//   its entries are undefined until loaded.
`include "nearest_point_search_2d_assert.svh"

module nearest_point_search_2d #(
   parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [9:0]                          req_slot,
   input  logic signed [nps_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [nps_pkg::COORD_W-1:0]  req_point_y,
   input  logic [15:0]                         req_query_tag,
   output logic                                rsp_strobe,
   output logic [15:0]                         rsp_query_index,
   output logic [9:0]                          rsp_nearest_index,
   output logic                                rsp_found,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nps_pkg::IDX_W-1:0]           csr_ref_count
);

   localparam int AW = $clog2(MAX_POINTS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [nps_pkg::IDX_W-1:0]          ref_count_ff;
   logic [nps_pkg::IDX_W-1:0]          count_eff;
   logic [nps_pkg::IDX_W-1:0]          cnt_ff, cnt_in;
   logic [nps_pkg::IDX_W-1:0]          j_ff, j_in;
   logic signed [nps_pkg::COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [15:0]                        tag_ff, tag_in;
   logic [nps_pkg::DIST_W-1:0]         best_d_ff, best_d_in;
   logic [nps_pkg::IDX_W-1:0]          best_j_ff, best_j_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [15:0]                        rsp_query_index_ff, rsp_query_index_in;
   logic [9:0]                         rsp_nearest_index_ff, rsp_nearest_index_in;
   logic                               rsp_found_ff, rsp_found_in;

   logic                               accept, is_query, slot_ok, scan_last, take;
   logic                               rd_en, wr_en;
   logic [AW-1:0]                      rd_addr, wr_addr;
   logic [nps_pkg::ENTRY_W-1:0]        wr_data, rd_data;
   logic [nps_pkg::DIST_W-1:0]         sq_dist;
   nps_pkg::nps_tag_type               issue_tag, tag_rd_ff, tag_rd_in, dist_tag;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_query  = (req_action == nps_pkg::ACT_QUERY);
   assign csr_ready = 1'b1;
   assign count_eff = (32'(ref_count_ff) > MAX_POINTS) ? nps_pkg::IDX_W'(MAX_POINTS)
                                                       : ref_count_ff;
   assign slot_ok   = (32'(req_slot) < MAX_POINTS);

   // Load path: straight into the RAM while idle
   assign wr_en   = accept && !is_query && slot_ok;
   assign wr_addr = AW'(req_slot);
   assign wr_data = {req_point_y, req_point_x};

   // Scan read issue
   assign scan_last = (j_ff == cnt_ff - nps_pkg::IDX_W'(1));
   assign rd_en     = (state_ff == ST_SCAN);
   assign rd_addr   = AW'(j_ff);

   always_comb begin
      issue_tag.valid = rd_en;
      issue_tag.first = (j_ff == '0);
      issue_tag.last  = scan_last;
      issue_tag.index = j_ff;
      tag_rd_in       = issue_tag;
   end

   nps_ram #(
      .WIDTH (nps_pkg::ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nps_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .query_x  (qx_ff),
      .query_y  (qy_ff),
      .ref_data (rd_data),
      .tag_in   (tag_rd_ff),
      .sq_dist  (sq_dist),
      .tag_out  (dist_tag)
   );

   always_comb begin
      state_in             = state_ff;
      cnt_in               = cnt_ff;
      j_in                 = j_ff;
      qx_in                = qx_ff;
      qy_in                = qy_ff;
      tag_in               = tag_ff;
      rsp_strobe_in        = 1'b0;
      rsp_query_index_in   = rsp_query_index_ff;
      rsp_nearest_index_in = rsp_nearest_index_ff;
      rsp_found_in         = rsp_found_ff;

      take      = dist_tag.valid && (dist_tag.first || (sq_dist < best_d_ff));
      best_d_in = take ? sq_dist : best_d_ff;
      best_j_in = take ? dist_tag.index : best_j_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               qx_in  = req_point_x;
               qy_in  = req_point_y;
               tag_in = req_query_tag;
               cnt_in = count_eff;
               j_in   = '0;
               if (count_eff == '0) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_query_index_in   = req_query_tag;
                  rsp_nearest_index_in = '0;
                  rsp_found_in         = 1'b0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            j_in = j_ff + nps_pkg::IDX_W'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in             = ST_IDLE;
               rsp_strobe_in        = 1'b1;
               rsp_query_index_in   = tag_ff;
               rsp_nearest_index_in = 10'(best_j_in);
               rsp_found_in         = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_count_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         tag_rd_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         tag_rd_ff     <= tag_rd_in;
         if (csr_valid && csr_ready) begin
            ref_count_ff <= csr_ref_count;
         end
      end
      cnt_ff               <= cnt_in;
      j_ff                 <= j_in;
      qx_ff                <= qx_in;
      qy_ff                <= qy_in;
      tag_ff               <= tag_in;
      best_d_ff            <= best_d_in;
      best_j_ff            <= best_j_in;
      rsp_query_index_ff   <= rsp_query_index_in;
      rsp_nearest_index_ff <= rsp_nearest_index_in;
      rsp_found_ff         <= rsp_found_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_query_index   = rsp_query_index_ff;
   assign rsp_nearest_index = rsp_nearest_index_ff;
   assign rsp_found         = rsp_found_ff;

   `NPS_ASSERT(a_rsp_when_idle, clock, reset, rsp_strobe |-> !busy)
   `NPS_ASSERT(a_pipe_only_busy, clock, reset, dist_tag.valid |-> busy)
   `NPS_ASSERT(a_scan_in_range, clock, reset, (state_ff == ST_SCAN) |-> (j_ff < cnt_ff))
   `NPS_ASSERT(a_empty_query, clock, reset,
      (accept && is_query && (count_eff == '0)) |=> (rsp_strobe && !rsp_found))
   `NPS_ASSERT_NEVER(a_no_read_idle, clock, reset, rd_en && (state_ff == ST_IDLE))

endmodule
